### rtl/utcal_pkg.sv
package utcal_pkg;

    // field widths
    localparam int EPOCH_W  = 32;
    localparam int ZONE_W   = 5;
    localparam int YEAR_W   = 8;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // calendar constants
    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_DAY  = 86400;
    localparam int BASE_YEAR     = 1970;
    localparam int LEAP_CYCLE    = 400;
    localparam int CENTURY       = 100;
    localparam int DAYS_PER_YEAR = 365;
    localparam int LAST_MONTH    = 11;

    // datapath widths
    localparam int REM_W  = 18;   // remainder before correction, below twice 86400
    localparam int DAYS_W = 16;   // whole days since 1970 fit in 16 bits
    localparam int PROD_W = 64;   // dividend times reciprocal
    localparam int CYC_W  = 9;    // year position in the 400 year cycle
    localparam int ZSEC_W = 17;   // zone offset in seconds, signed

    // reciprocals: floor(2^48 / 86400), floor(2^32 / 3600), floor(2^32 / 60)
    // the day quotient is product bits 63:48, the others bits 47:32
    localparam logic [EPOCH_W-1:0] RECIP_DAY  = 32'd3257812230;
    localparam logic [EPOCH_W-1:0] RECIP_HOUR = 32'd1193046;
    localparam logic [EPOCH_W-1:0] RECIP_MIN  = 32'd71582788;

    localparam logic [4:0] MONTH_DAYS [2][12] = '{
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31},
        '{5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31}
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_DAY,
        S_LD_HOUR,
        S_DIV_HOUR,
        S_LD_MIN,
        S_DIV_MIN,
        S_LD_YEAR,
        S_YEAR,
        S_MONTH
    } t_state;

    // steps of one divide pass
    typedef enum logic [1:0] {
        PH_MUL,
        PH_REM,
        PH_FIX
    } t_phase;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_MUL,
        OP_DIV_REM,
        OP_DIV_FIX,
        OP_LOAD_HOUR,
        OP_LOAD_MIN,
        OP_LOAD_YEAR,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_PUBLISH
    } t_op;

    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_HOUR,
        DSEL_MIN
    } t_dsel;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } t_stat;

    typedef struct packed {
        logic [YEAR_W-1:0]   years_since_1970;
        logic [MONTH_W-1:0]  month_number;
        logic [DAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MINUTE_W-1:0] minute_of_hour;
        logic [SECOND_W-1:0] second_of_minute;
    } t_result;

    function automatic logic [REM_W-1:0] divisor(input t_dsel sel);
        logic [REM_W-1:0] d;
        case (sel)
            DSEL_DAY:  d = REM_W'(SECS_PER_DAY);
            DSEL_HOUR: d = REM_W'(SECS_PER_HOUR);
            DSEL_MIN:  d = REM_W'(SECS_PER_MIN);
            default:   d = REM_W'(SECS_PER_DAY);
        endcase
        return d;
    endfunction

    function automatic logic [EPOCH_W-1:0] recip(input t_dsel sel);
        logic [EPOCH_W-1:0] m;
        case (sel)
            DSEL_DAY:  m = RECIP_DAY;
            DSEL_HOUR: m = RECIP_HOUR;
            DSEL_MIN:  m = RECIP_MIN;
            default:   m = RECIP_DAY;
        endcase
        return m;
    endfunction

    // gregorian rule from the position in the 400 year cycle
    function automatic logic is_leap(input logic [CYC_W-1:0] cyc);
        return (cyc[1:0] == 2'b00)
            && (cyc != CYC_W'(CENTURY))
            && (cyc != CYC_W'(2 * CENTURY))
            && (cyc != CYC_W'(3 * CENTURY));
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [MONTH_W-1:0] mon);
        logic [4:0] len;
        if (mon > MONTH_W'(LAST_MONTH)) begin
            len = 5'd0;
        end else begin
            len = MONTH_DAYS[leap][mon];
        end
        return len;
    endfunction

endpackage

### rtl/utcal_if.sv
interface utcal_in_if;
    logic                            valid;
    logic                            ready;
    logic [utcal_pkg::EPOCH_W-1:0]   epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface utcal_out_if;
    logic                            valid;
    logic                            ready;
    logic [utcal_pkg::YEAR_W-1:0]    years_since_1970;
    logic [utcal_pkg::MONTH_W-1:0]   month_number;
    logic [utcal_pkg::DAY_W-1:0]     day_of_month;
    logic [utcal_pkg::HOUR_W-1:0]    hour_of_day;
    logic [utcal_pkg::MINUTE_W-1:0]  minute_of_hour;
    logic [utcal_pkg::SECOND_W-1:0]  second_of_minute;

    modport source (output valid, output years_since_1970, output month_number,
                    output day_of_month, output hour_of_day, output minute_of_hour,
                    output second_of_minute, input ready);
    modport sink   (input valid, input years_since_1970, input month_number,
                    input day_of_month, input hour_of_day, input minute_of_hour,
                    input second_of_minute, output ready);
endinterface

### rtl/utcal_ctrl.sv
module utcal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  utcal_pkg::t_stat i_stat,
    output utcal_pkg::t_op   o_op,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import utcal_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_out_valid, n_out_valid;
    logic   div_state;
    logic   div_last;
    logic   out_free;

    assign div_state = (r_state == S_DIV_DAY) || (r_state == S_DIV_HOUR)
                    || (r_state == S_DIV_MIN);
    assign div_last  = div_state && (r_phase == PH_FIX);

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DIV_DAY;
            S_DIV_DAY:  if (div_last) n_state = S_LD_HOUR;
            S_LD_HOUR:  n_state = S_DIV_HOUR;
            S_DIV_HOUR: if (div_last) n_state = S_LD_MIN;
            S_LD_MIN:   n_state = S_DIV_MIN;
            S_DIV_MIN:  if (div_last) n_state = S_LD_YEAR;
            S_LD_YEAR:  n_state = S_YEAR;
            S_YEAR:     if (!i_stat.year_fit) n_state = S_MONTH;
            S_MONTH:    if (!i_stat.month_fit && out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_op = OP_LOAD;
            end
            S_DIV_DAY, S_DIV_HOUR, S_DIV_MIN: begin
                case (r_phase)
                    PH_MUL:  o_op = OP_DIV_MUL;
                    PH_REM:  o_op = OP_DIV_REM;
                    default: o_op = OP_DIV_FIX;
                endcase
            end
            S_LD_HOUR: o_op = OP_LOAD_HOUR;
            S_LD_MIN:  o_op = OP_LOAD_MIN;
            S_LD_YEAR: o_op = OP_LOAD_YEAR;
            S_YEAR:    o_op = OP_YEAR_STEP;
            S_MONTH: begin
                if (i_stat.month_fit) begin
                    o_op = OP_MONTH_STEP;
                end else if (out_free) begin
                    o_op = OP_PUBLISH;
                end
            end
            default:   o_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_phase = PH_MUL;
        if (div_state) begin
            case (r_phase)
                PH_MUL:  n_phase = PH_REM;
                PH_REM:  n_phase = PH_FIX;
                default: n_phase = PH_MUL;
            endcase
        end
        n_out_valid = r_out_valid;
        if (o_op == OP_PUBLISH) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_MUL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/utcal_dp.sv
module utcal_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic signed [utcal_pkg::ZONE_W-1:0] i_cfg_wr_data,
    input  logic [utcal_pkg::EPOCH_W-1:0]     i_epoch_seconds,
    input  utcal_pkg::t_op                    i_op,
    output utcal_pkg::t_stat                  o_stat,
    output utcal_pkg::t_result                o_result
);
    import utcal_pkg::*;

    logic signed [ZONE_W-1:0] r_zone;
    logic [EPOCH_W-1:0]       r_x, n_x;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [DAYS_W-1:0]        r_q, n_q;
    logic [REM_W-1:0]         r_rem, n_rem;
    t_dsel                    r_dsel, n_dsel;
    logic [DAYS_W-1:0]        r_days, n_days;
    logic [HOUR_W-1:0]        r_hour, n_hour;
    logic [MINUTE_W-1:0]      r_min, n_min;
    logic [SECOND_W-1:0]      r_sec, n_sec;
    logic [YEAR_W-1:0]        r_year, n_year;
    logic [CYC_W-1:0]         r_cyc, n_cyc;
    logic [MONTH_W-1:0]       r_mon, n_mon;
    t_result                  r_res, n_res;

    logic signed [ZSEC_W-1:0] zone_ext;
    logic signed [ZSEC_W-1:0] zone_secs;
    logic [EPOCH_W-1:0]       local_secs;
    logic [REM_W-1:0]         div_const;
    logic [DAYS_W-1:0]        q_est;
    logic [EPOCH_W-1:0]       q_times_d;
    logic                     rem_ge;
    logic                     leap;
    logic [DAYS_W-1:0]        year_len;
    logic [DAYS_W-1:0]        mon_len;

    assign zone_ext   = {{(ZSEC_W - ZONE_W){r_zone[ZONE_W-1]}}, r_zone};
    assign zone_secs  = zone_ext * ZSEC_W'(SECS_PER_HOUR);
    assign local_secs = i_epoch_seconds
                      + {{(EPOCH_W - ZSEC_W){zone_secs[ZSEC_W-1]}}, zone_secs};

    // divide by constant: reciprocal product, quotient estimate low by at
    // most one, then a single compare and subtract
    assign div_const = divisor(r_dsel);
    assign q_est     = (r_dsel == DSEL_DAY) ? r_prod[PROD_W-1:PROD_W-DAYS_W]
                                            : r_prod[EPOCH_W+DAYS_W-1:EPOCH_W];
    assign q_times_d = EPOCH_W'(q_est) * EPOCH_W'(div_const);
    assign rem_ge    = (r_rem >= div_const);

    assign leap     = is_leap(r_cyc);
    assign year_len = DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(leap);
    assign mon_len  = DAYS_W'(month_len(leap, r_mon));

    assign o_stat.year_fit  = (r_days >= year_len);
    assign o_stat.month_fit = (r_mon != MONTH_W'(LAST_MONTH)) && (r_days >= mon_len);

    always_comb begin
        n_x    = r_x;
        n_prod = r_prod;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dsel = r_dsel;
        n_days = r_days;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_year = r_year;
        n_cyc  = r_cyc;
        n_mon  = r_mon;
        n_res  = r_res;
        case (i_op)
            OP_LOAD: begin
                n_x    = local_secs;
                n_dsel = DSEL_DAY;
            end
            OP_DIV_MUL: begin
                n_prod = PROD_W'(r_x) * PROD_W'(recip(r_dsel));
            end
            OP_DIV_REM: begin
                n_q   = q_est;
                n_rem = REM_W'(r_x - q_times_d);
            end
            OP_DIV_FIX: begin
                if (rem_ge) begin
                    n_q   = r_q + DAYS_W'(1);
                    n_rem = r_rem - div_const;
                end
            end
            OP_LOAD_HOUR: begin
                n_days = r_q;
                n_x    = EPOCH_W'(r_rem);
                n_dsel = DSEL_HOUR;
            end
            OP_LOAD_MIN: begin
                n_hour = r_q[HOUR_W-1:0];
                n_x    = EPOCH_W'(r_rem);
                n_dsel = DSEL_MIN;
            end
            OP_LOAD_YEAR: begin
                n_min  = r_q[MINUTE_W-1:0];
                n_sec  = r_rem[SECOND_W-1:0];
                n_year = '0;
                n_cyc  = CYC_W'(BASE_YEAR % LEAP_CYCLE);
                n_mon  = '0;
            end
            OP_YEAR_STEP: begin
                if (o_stat.year_fit) begin
                    n_days = r_days - year_len;
                    n_year = r_year + YEAR_W'(1);
                    n_cyc  = (r_cyc == CYC_W'(LEAP_CYCLE - 1)) ? '0 : r_cyc + CYC_W'(1);
                end
            end
            OP_MONTH_STEP: begin
                if (o_stat.month_fit) begin
                    n_days = r_days - mon_len;
                    n_mon  = r_mon + MONTH_W'(1);
                end
            end
            OP_PUBLISH: begin
                n_res.years_since_1970 = r_year;
                n_res.month_number     = r_mon + MONTH_W'(1);
                n_res.day_of_month     = r_days[DAY_W-1:0] + DAY_W'(1);
                n_res.hour_of_day      = r_hour;
                n_res.minute_of_hour   = r_min;
                n_res.second_of_minute = r_sec;
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_wr_en) begin
            r_zone <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_dsel <= n_dsel;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_year <= n_year;
        r_cyc  <= n_cyc;
        r_mon  <= n_mon;
        r_res  <= n_res;
    end

    assign o_result = r_res;

endmodule

### rtl/unix_time_to_calendar.sv
// sequence from input accept to output valid: a divide pass (reciprocal multiply,
// remainder, correction) each for days, hours and minutes, with load steps around
// them, then the year loop, one step per whole year (Y = 0..136), and the month
// loop, one step per month index (M = 0..11), then the hand-off to the output
// one word is converted at a time; the next is taken once the last is published
// reset: synchronous active low, clears the controller and sets the zone register to 0
module unix_time_to_calendar (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic signed [utcal_pkg::ZONE_W-1:0] i_cfg_wr_data,
    utcal_in_if.sink                            i_in,
    utcal_out_if.source                         o_out
);
    import utcal_pkg::*;

    t_op     op;
    t_stat   stat;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    // controller: sequences divide passes, year loop, month loop and the
    // hand-off into the output register
    utcal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_op        (op),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    // datapath: zone add, shared divide-by-constant unit using reciprocal
    // multiplication (days, then hours, then minutes), year and month subtractors
    utcal_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_epoch_seconds (i_in.epoch_seconds),
        .i_op            (op),
        .o_stat          (stat),
        .o_result        (result)
    );

    // input side is free again while the last result waits in the output register
    assign i_in.ready = in_ready;

    assign o_out.valid            = out_valid;
    assign o_out.years_since_1970 = result.years_since_1970;
    assign o_out.month_number     = result.month_number;
    assign o_out.day_of_month     = result.day_of_month;
    assign o_out.hour_of_day      = result.hour_of_day;
    assign o_out.minute_of_hour   = result.minute_of_hour;
    assign o_out.second_of_minute = result.second_of_minute;

`ifndef SYNTH
    // an accepted word keeps the block busy for the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready did not drop after accept");

    // published date fields stay in calendar range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.month_number >= 4'd1 && o_out.month_number <= 4'd12
                         && o_out.day_of_month >= 5'd1
                         && o_out.years_since_1970 <= 8'd136))
        else $error("date field out of range");

    // published time fields stay in clock range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hour_of_day < 5'd24 && o_out.minute_of_hour < 6'd60
                         && o_out.second_of_minute < 6'd60))
        else $error("time field out of range");
`endif

endmodule

### tb/sv/unix_time_to_calendar_tb.sv
`timescale 1ns / 1ps

module unix_time_to_calendar_tb;
    import utcal_pkg::*;

    // run shape
    localparam int CLK_HALF     = 2;
    localparam int DIR_ROWS     = 21;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 181;
    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 600;
    // long enough to cover one last conversion at the slowest word
    localparam int DRAIN_CYCLES = 250;
    // slowest word plus idling on both sides, times a wide margin
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int MAX_PRINTS   = 100;

    // gregorian month lengths, normal year then leap year
    localparam int MONTH_LEN_TAB [2][12] = '{
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31},
        '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31}
    };

    // one row of the directed table: zone to apply, word to send, and an
    // optional hand-typed result where it is obvious
    typedef struct {
        logic [ZONE_W-1:0]  zone;
        logic [EPOCH_W-1:0] epoch;
        bit                 typed;
        t_result            want;
    } t_dir_row;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic signed [ZONE_W-1:0] cfg_wr_data;

    utcal_in_if  in_if ();
    utcal_out_if out_if ();

    unix_time_to_calendar u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // dates still owed by the block, oldest first
    t_result           pending_dates [$];
    logic [ZONE_W-1:0] zone_now;
    int unsigned       mismatches;
    int unsigned       cycle_count;
    // both sides stop idling while set
    bit                quiet;
    // asks the receiver for one long hold-off
    bit                hold_req;
    t_dir_row          dir_rows [DIR_ROWS];

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic bit leap_year(input int unsigned yr);
        if (yr % 4 != 0) return 1'b0;
        if (yr % 100 != 0) return 1'b1;
        return (yr % 400 == 0);
    endfunction

    // local calendar date for one word under the given zone pattern
    function automatic t_result calc_calendar(input logic [EPOCH_W-1:0] stamp,
                                              input logic [ZONE_W-1:0] zone);
        logic [EPOCH_W-1:0] local_secs;
        int unsigned        days;
        int unsigned        yr;
        int unsigned        mon;
        bit                 lp;
        t_result            r;
        // sign-extended zone times 3600, wrapping modulo 2^32
        local_secs = stamp + {{(EPOCH_W-ZONE_W){zone[ZONE_W-1]}}, zone} * 32'd3600;
        days = local_secs / 32'd86400;
        yr = 1970;
        while (days >= 365 + int'(leap_year(yr))) begin
            days -= 365 + int'(leap_year(yr));
            yr++;
        end
        lp = leap_year(yr);
        mon = 0;
        while (mon < 11 && days >= MONTH_LEN_TAB[lp][mon]) begin
            days -= MONTH_LEN_TAB[lp][mon];
            mon++;
        end
        r.years_since_1970 = YEAR_W'(yr - 1970);
        r.month_number     = MONTH_W'(mon + 1);
        r.day_of_month     = DAY_W'(days + 1);
        r.hour_of_day      = HOUR_W'((local_secs / 32'd3600) % 24);
        r.minute_of_hour   = MINUTE_W'((local_secs / 32'd60) % 60);
        r.second_of_minute = SECOND_W'(local_secs % 60);
        return r;
    endfunction

    // random word: mostly uniform, the rest near both ends of the range and
    // right around UTC midnights, where day, month and year roll over
    function automatic logic [EPOCH_W-1:0] next_epoch();
        int unsigned        pick;
        logic [EPOCH_W-1:0] e;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            e = $urandom();
        end else if (pick < 65) begin
            e = $urandom_range(0, 2 * 86400);
        end else if (pick < 75) begin
            e = 32'hFFFF_FFFF - $urandom_range(0, 2 * 86400);
        end else begin
            e = 32'($urandom_range(0, 49710)) * 32'd86400 - 32'd1
                + 32'($urandom_range(0, 2));
        end
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    task automatic compare_date(input t_result want);
        check_field("years_since_1970", 32'(out_if.years_since_1970),
                    32'(want.years_since_1970));
        check_field("month_number", 32'(out_if.month_number), 32'(want.month_number));
        check_field("day_of_month", 32'(out_if.day_of_month), 32'(want.day_of_month));
        check_field("hour_of_day", 32'(out_if.hour_of_day), 32'(want.hour_of_day));
        check_field("minute_of_hour", 32'(out_if.minute_of_hour),
                    32'(want.minute_of_hour));
        check_field("second_of_minute", 32'(out_if.second_of_minute),
                    32'(want.second_of_minute));
    endtask

    // offer one word, idling first at random, and log its date on accept;
    // valid stays high on return so back-to-back words need no reassertion
    task automatic send_epoch(input logic [EPOCH_W-1:0] e, input bit typed,
                              input t_result want);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.epoch_seconds <= e;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        pending_dates.push_back(typed ? want : calc_calendar(e, zone_now));
    endtask

    // zone changes only once the block has handed back every date
    task automatic write_zone(input logic [ZONE_W-1:0] z);
        in_if.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= z;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        zone_now  = z;
    endtask

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // checker: every accepted word must match the oldest date owed
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("word with no date pending", 0, 0);
            end else begin
                compare_date(pending_dates.pop_front());
            end
        end
    end

    // stimulus
    initial begin
        logic [ZONE_W-1:0] zone_plan [RAND_PHASES];
        mismatches          = 0;
        quiet               = 1'b0;
        hold_req            = 1'b0;
        zone_now            = '0;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        in_if.valid         = 1'b0;
        in_if.epoch_seconds = '0;

        // directed rows grouped by zone; typed dates are the epoch itself,
        // the last second of the 32-bit range and two trivial zone cases
        dir_rows = '{
            '{5'd0, 32'd0, 1'b1, '{8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
            '{5'd0, 32'hFFFF_FFFF, 1'b1, '{8'd136, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}},
            '{5'd0, 32'd68169599, 1'b0, '0},     // eve of the first leap day
            '{5'd0, 32'd68169600, 1'b0, '0},     // leap day 1972
            '{5'd0, 32'd951782400, 1'b0, '0},    // leap day of a 400-year century
            '{5'd0, 32'd946684799, 1'b0, '0},    // last second of 1999
            '{5'd0, 32'd4107542399, 1'b0, '0},   // end of february, 2100 not leap
            '{5'd0, 32'd4107542400, 1'b0, '0},
            '{5'd0, 32'h8000_0000, 1'b0, '0},
            '{5'd14, 32'd0, 1'b0, '0},
            '{5'd14, 32'hFFFF_FFFF, 1'b0, '0},   // sum wraps past the top
            '{5'(-12), 32'd0, 1'b0, '0},         // sum wraps below zero
            '{5'(-12), 32'hFFFF_FFFF, 1'b0, '0},
            '{5'(-16), 32'd0, 1'b0, '0},         // zone outside nominal range
            '{5'(-16), 32'd57599, 1'b0, '0},
            '{5'd15, 32'hFFFF_FFFF, 1'b1, '{8'd0, 4'd1, 5'd1, 5'd14, 6'd59, 6'd59}},
            '{5'd15, 32'd0, 1'b0, '0},
            '{5'(-1), 32'd0, 1'b0, '0},
            '{5'(-1), 32'd3600, 1'b1, '{8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
            '{5'd1, 32'h5555_5555, 1'b0, '0},
            '{5'd1, 32'hAAAA_AAAA, 1'b0, '0}
        };

        zone_plan[0] = 5'd0;
        zone_plan[1] = 5'(-12);
        zone_plan[2] = 5'd14;
        zone_plan[3] = 5'(-16);
        zone_plan[4] = 5'd15;
        for (int p = 5; p < RAND_PHASES; p++) zone_plan[p] = ZONE_W'($urandom_range(0, 31));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: rewrite the zone whenever the table moves to a new one
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == 0 || dir_rows[i].zone != zone_now) write_zone(dir_rows[i].zone);
            send_epoch(dir_rows[i].epoch, dir_rows[i].typed, dir_rows[i].want);
        end

        // random part: one zone per phase; phase 1 gets the long receiver
        // hold-off while words keep coming, phase 2 runs with no idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_zone(zone_plan[p]);
            quiet = (p == 2);
            if (p == 1) hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) send_epoch(next_epoch(), 1'b0, '0);
        end
        quiet = 1'b0;
        in_if.valid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge clk);
        // room for a stray extra word to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
